FILE: rtl/psf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psf_pkg;

    // Fixed geometry of the packed monochrome frame buffer
    localparam int COL_W       = 10;
    localparam int WORD_BITS   = 16;
    localparam int WSHIFT      = 4;
    localparam int WIDX_W      = COL_W - WSHIFT;
    localparam int ADDR_W      = 24;
    localparam int PITCH_W     = 11;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PATT_GROUPS = 4;
    localparam int MAX_COLUMNS = 1024;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [COL_W-1:0]     COL_LAST   = COL_W'(MAX_COLUMNS - 1);
    localparam logic [WORD_BITS-1:0] WORD_ONES  = {WORD_BITS{1'b1}};
    localparam logic [3:0]           BIT_LAST   = 4'(WORD_BITS - 1);

    localparam logic [MODE_W-1:0]     MODE_RESET  = 2'd1;
    localparam logic [PITCH_W-1:0]    PITCH_RESET = 11'd64;
    localparam logic [ADDR_W-1:0]     BASE_RESET  = '0;
    localparam logic [CFG_DATA_W-1:0] PATT_RESET  = {CFG_DATA_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAW_MODE     = 3'd0,
        CFG_WORDS_PER_ROW = 3'd1,
        CFG_FRAME_BASE    = 3'd2,
        CFG_PATT_A        = 3'd3,
        CFG_PATT_B        = 3'd4,
        CFG_PATT_C        = 3'd5,
        CFG_PATT_D        = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]                        draw_mode;
        logic [PITCH_W-1:0]                       words_per_row;
        logic [ADDR_W-1:0]                        frame_base;
        logic [PATT_GROUPS-1:0][CFG_DATA_W-1:0]   patt;
    } t_cfg;

    // One classified span, ready for the word walker
    typedef struct packed {
        logic [ADDR_W-1:0]    row_addr;
        logic [WIDX_W-1:0]    wfirst;
        logic [WIDX_W-1:0]    wlast;
        logic [WORD_BITS-1:0] lmask;
        logic [WORD_BITS-1:0] rmask;
        logic [WORD_BITS-1:0] patt;
        logic [MODE_W-1:0]    rop;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/psf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module psf_front
    import psf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [COL_W-1:0]  i_x_first,
    input  wire logic [COL_W-1:0]  i_x_second,
    input  wire logic [COL_W-1:0]  i_row,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output t_cmd                   o_cmd
);

    logic             r_valid;
    logic             n_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic [COL_W-1:0] xa;
    logic [COL_W-1:0] xb;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [3:0]       pidx;
    logic [CFG_DATA_W-1:0] grp;
    logic [COL_W+PITCH_W-1:0] row_off;
    logic             accept;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        // saturate columns, then order the ends
        xa = (i_x_first  > COL_LAST) ? COL_LAST : i_x_first;
        xb = (i_x_second > COL_LAST) ? COL_LAST : i_x_second;
        if (xb < xa) begin
            left  = xb;
            right = xa;
        end else begin
            left  = xa;
            right = xb;
        end
        pidx    = i_row[3:0];
        grp     = i_cfg.patt[pidx[3:2]];
        row_off = (COL_W+PITCH_W)'(i_row) * (COL_W+PITCH_W)'(i_cfg.words_per_row);

        n_cmd.row_addr = i_cfg.frame_base + ADDR_W'(row_off);
        n_cmd.wfirst   = left[COL_W-1:WSHIFT];
        n_cmd.wlast    = right[COL_W-1:WSHIFT];
        n_cmd.lmask    = WORD_ONES >> left[3:0];
        n_cmd.rmask    = WORD_BITS'(WORD_ONES << (BIT_LAST - right[3:0]));
        n_cmd.patt     = grp[{pidx[1:0], 4'b0000} +: WORD_BITS];
        n_cmd.rop      = i_cfg.draw_mode;
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/psf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module psf_queue
    import psf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/psf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module psf_back
    import psf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    output logic                       o_cmd_ready,
    input  wire t_cmd                  i_cmd,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [ADDR_W-1:0]          o_word_address,
    output logic [WORD_BITS-1:0]       o_bit_mask,
    output logic [WORD_BITS-1:0]       o_pattern_word,
    output logic [MODE_W-1:0]          o_raster_op,
    output logic                       o_last_word
);

    logic                  r_busy;
    logic                  n_busy;
    t_cmd                  r_cmd;
    logic [WIDX_W-1:0]     r_w;
    logic [WIDX_W-1:0]     n_w;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [ADDR_W-1:0]     r_addr;
    logic [WORD_BITS-1:0]  r_mask;
    logic [WORD_BITS-1:0]  r_patt;
    logic [MODE_W-1:0]     r_rop;
    logic                  r_last;
    logic                  emit;
    logic                  at_last;
    logic                  load;
    logic [WORD_BITS-1:0]  mask;

    assign at_last     = (r_w == r_cmd.wlast);
    assign emit        = r_busy && (!r_out_valid || i_out_ready);
    // take the next span as the current one hands out its last word
    assign o_cmd_ready = !r_busy || (emit && at_last);
    assign load        = i_cmd_valid && o_cmd_ready;

    always_comb begin
        mask = WORD_ONES;
        if (r_w == r_cmd.wfirst) begin
            mask = mask & r_cmd.lmask;
        end
        if (at_last) begin
            mask = mask & r_cmd.rmask;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_w         = r_w;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_w    = i_cmd.wfirst;
        end else if (emit && at_last) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_w = r_w + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_w         <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_w         <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_addr <= r_cmd.row_addr + ADDR_W'(r_w);
            r_mask <= mask;
            r_patt <= r_cmd.patt;
            r_rop  <= r_cmd.rop;
            r_last <= at_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_address = r_addr;
    assign o_bit_mask     = r_mask;
    assign o_pattern_word = r_patt;
    assign o_raster_op    = r_rop;
    assign o_last_word    = r_last;

endmodule

`default_nettype wire

FILE: rtl/patterned_span_fill.sv
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_x_first, i_x_second, i_row
// out       o_out_valid / i_out_ready  o_word_address, o_bit_mask, o_pattern_word,
//                                      o_raster_op, o_last_word
// cfg       i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// A span of N words gives N beats from the walker, one per cycle unless stalled.
// Spans follow without a gap; the front takes a new span while passing one on.
// A span goes through the front register, queue and walker to the output register.
// Reset (synchronous, active low) empties the queue and the output register.
// Output stalls hold the walker; the queue lets the front keep accepting.
`timescale 1ns / 1ps
`default_nettype none

module patterned_span_fill
    import psf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [COL_W-1:0]      i_x_first,
    input  wire logic [COL_W-1:0]      i_x_second,
    input  wire logic [COL_W-1:0]      i_row,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [ADDR_W-1:0]          o_word_address,
    output logic [WORD_BITS-1:0]       o_bit_mask,
    output logic [WORD_BITS-1:0]       o_pattern_word,
    output logic [MODE_W-1:0]          o_raster_op,
    output logic                       o_last_word
);

    t_cfg r_cfg;
    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic back_valid;
    logic back_ready;
    t_cmd back_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draw_mode     <= MODE_RESET;
            r_cfg.words_per_row <= PITCH_RESET;
            r_cfg.frame_base    <= BASE_RESET;
            r_cfg.patt          <= {PATT_GROUPS{PATT_RESET}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DRAW_MODE:     r_cfg.draw_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_WORDS_PER_ROW: r_cfg.words_per_row <= i_cfg_data[PITCH_W-1:0];
                CFG_FRAME_BASE:    r_cfg.frame_base    <= i_cfg_data[ADDR_W-1:0];
                CFG_PATT_A:        r_cfg.patt[0]       <= i_cfg_data;
                CFG_PATT_B:        r_cfg.patt[1]       <= i_cfg_data;
                CFG_PATT_C:        r_cfg.patt[2]       <= i_cfg_data;
                CFG_PATT_D:        r_cfg.patt[3]       <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    psf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_first   (i_x_first),
        .i_x_second  (i_x_second),
        .i_row       (i_row),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    psf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_cmd   (back_cmd)
    );

    psf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (back_valid),
        .o_cmd_ready    (back_ready),
        .i_cmd          (back_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_word_address (o_word_address),
        .o_bit_mask     (o_bit_mask),
        .o_pattern_word (o_pattern_word),
        .o_raster_op    (o_raster_op),
        .o_last_word    (o_last_word)
    );

endmodule

`default_nettype wire

FILE: rtl/psf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psf_checker
    import psf_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [ADDR_W-1:0]    o_word_address,
    input wire logic [WORD_BITS-1:0] o_bit_mask,
    input wire logic [WORD_BITS-1:0] o_pattern_word,
    input wire logic                 o_last_word
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_word_address)
            && $stable(o_bit_mask) && $stable(o_last_word))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bit_mask != '0))
        else $error("empty bit mask");

    // inside a span the walker advances one word with no gap
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && (o_word_address == $past(o_word_address) + 1'b1)
            && o_bit_mask[WORD_BITS-1] && (o_pattern_word == $past(o_pattern_word)))
        else $error("span words not contiguous");

    a_inner_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_word |-> o_bit_mask[0])
        else $error("non-final word not filled to its right edge");

endmodule

bind patterned_span_fill psf_checker u_psf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_word_address (o_word_address),
    .o_bit_mask     (o_bit_mask),
    .o_pattern_word (o_pattern_word),
    .o_last_word    (o_last_word)
);

`default_nettype wire

FILE: verif/patterned_span_fill_test.sv
`timescale 1ns / 1ps

module patterned_span_fill_test;
    import psf_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_SPANS  = 31;

    // No register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct {
        logic [ADDR_W-1:0]    word_address;
        logic [WORD_BITS-1:0] bit_mask;
        logic [WORD_BITS-1:0] pattern_word;
        logic [MODE_W-1:0]    raster_op;
        logic                 last_word;
    } t_word_op;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COL_W-1:0]      x_first = '0;
    logic [COL_W-1:0]      x_second = '0;
    logic [COL_W-1:0]      span_row = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ADDR_W-1:0]     word_address;
    logic [WORD_BITS-1:0]  bit_mask;
    logic [WORD_BITS-1:0]  pattern_word;
    logic [MODE_W-1:0]     raster_op;
    logic                  last_word;

    t_cfg     fb_cfg;
    t_word_op pending_words[$];
    int       errors = 0;
    int       cycles = 0;
    bit       in_idle = 1'b1;
    bit       out_idle = 1'b1;
    int       hold_req = 0;
    int       rx_hold = 0;
    int       rx_wait = 0;

    patterned_span_fill i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_x_first      (x_first),
        .i_x_second     (x_second),
        .i_row          (span_row),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_word_address (word_address),
        .o_bit_mask     (bit_mask),
        .o_pattern_word (pattern_word),
        .o_raster_op    (raster_op),
        .o_last_word    (last_word)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Expected word operations of one span, left to right
    function automatic void queue_span_words(logic [COL_W-1:0] xa, logic [COL_W-1:0] xb,
                                             logic [COL_W-1:0] r);
        logic [COL_W-1:0]     left;
        logic [COL_W-1:0]     right;
        logic [ADDR_W-1:0]    row_addr;
        logic [WORD_BITS-1:0] patt_row;
        int                   w;
        int                   wfirst;
        int                   wlast;
        t_word_op             op;
        left     = (xb < xa) ? xb : xa;
        right    = (xb < xa) ? xa : xb;
        wfirst   = int'(left[COL_W-1:WSHIFT]);
        wlast    = int'(right[COL_W-1:WSHIFT]);
        row_addr = ADDR_W'(32'(fb_cfg.frame_base) + 32'(r) * 32'(fb_cfg.words_per_row));
        patt_row = fb_cfg.patt[r[3:2]][WORD_BITS * r[1:0] +: WORD_BITS];
        for (w = wfirst; w <= wlast; w++) begin
            op.bit_mask = WORD_ONES;
            if (w == wfirst)
                op.bit_mask &= WORD_ONES >> left[WSHIFT-1:0];
            if (w == wlast)
                op.bit_mask &= WORD_ONES << (BIT_LAST - right[WSHIFT-1:0]);
            op.word_address = ADDR_W'(32'(row_addr) + w);
            op.pattern_word = patt_row;
            op.raster_op    = fb_cfg.draw_mode;
            op.last_word    = (w == wlast);
            pending_words.push_back(op);
        end
    endfunction

    // Output side: random stalls per beat while out_idle is set, long hold on request, compare every beat
    always @(posedge i_clk) begin
        t_word_op exp_op;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected beat: word_address %h", word_address);
                    errors++;
                end else begin
                    exp_op = pending_words.pop_front();
                    if (word_address !== exp_op.word_address) begin
                        $error("word_address: expected %h, got %h",
                               exp_op.word_address, word_address);
                        errors++;
                    end
                    if (bit_mask !== exp_op.bit_mask) begin
                        $error("bit_mask: expected %h, got %h", exp_op.bit_mask, bit_mask);
                        errors++;
                    end
                    if (pattern_word !== exp_op.pattern_word) begin
                        $error("pattern_word: expected %h, got %h",
                               exp_op.pattern_word, pattern_word);
                        errors++;
                    end
                    if (raster_op !== exp_op.raster_op) begin
                        $error("raster_op: expected %0d, got %0d", exp_op.raster_op, raster_op);
                        errors++;
                    end
                    if (last_word !== exp_op.last_word) begin
                        $error("last_word: expected %b, got %b", exp_op.last_word, last_word);
                        errors++;
                    end
                end
                rx_wait = out_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_req > 0) begin
                rx_hold  = hold_req;
                hold_req = 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DRAW_MODE:     fb_cfg.draw_mode = value[MODE_W-1:0];
            CFG_WORDS_PER_ROW: fb_cfg.words_per_row = value[PITCH_W-1:0];
            CFG_FRAME_BASE:    fb_cfg.frame_base = value[ADDR_W-1:0];
            CFG_PATT_A:        fb_cfg.patt[0] = value;
            CFG_PATT_B:        fb_cfg.patt[1] = value;
            CFG_PATT_C:        fb_cfg.patt[2] = value;
            CFG_PATT_D:        fb_cfg.patt[3] = value;
            default: ;
        endcase
    endtask

    // Offer one span; valid stays up across back-to-back spans when no gap is drawn
    task automatic send_span(logic [COL_W-1:0] xa, logic [COL_W-1:0] xb, logic [COL_W-1:0] r);
        int gap;
        gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        x_first  <= xa;
        x_second <= xb;
        span_row <= r;
        do @(posedge i_clk); while (!in_ready);
        queue_span_words(xa, xb, r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_config();
        send_span(10'd0, 10'd0, 10'd0);          // single pixel
        send_span(10'd0, 10'd1023, 10'd5);       // whole row
        send_span(10'd40, 10'd3, 10'd17);        // reversed ends
        send_span(10'd16, 10'd31, 10'd2);        // exactly one word
        send_span(10'd5, 10'd9, 10'd1023);       // inside one word
        send_span(10'd15, 10'd16, 10'd512);      // straddle a word boundary
        send_span(10'd1023, 10'd1023, 10'd1023); // last column
        send_span(10'd1023, 10'd1008, 10'd341);
        drain();
    endtask

    task automatic test_register_extremes();
        cfg_write(CFG_DRAW_MODE, 64'd0);
        cfg_write(CFG_WORDS_PER_ROW, 64'd0);
        cfg_write(CFG_FRAME_BASE, 64'hFF_FFFF);
        send_span(10'd1000, 10'd1023, 10'd1023);
        send_span(10'd31, 10'd0, 10'd1);
        drain();

        // widest pitch past the top of the address space: addresses wrap
        cfg_write(CFG_DRAW_MODE, 64'd3);
        cfg_write(CFG_WORDS_PER_ROW, 64'd2047);
        cfg_write(CFG_FRAME_BASE, 64'hFF_FFF0);
        send_span(10'd1023, 10'd0, 10'd1023);
        drain();

        cfg_write(CFG_DRAW_MODE, 64'd2);
        cfg_write(CFG_WORDS_PER_ROW, 64'd1024);
        cfg_write(CFG_FRAME_BASE, 64'h12_3456);
        cfg_write(CFG_PATT_A, 64'h0001_8000_5555_AAAA);
        cfg_write(CFG_PATT_B, 64'hFFFF_0000_1234_F00F);
        cfg_write(CFG_PATT_C, 64'h7FFE_C3C3_0F0F_FE01);
        cfg_write(CFG_PATT_D, 64'h0000_0000_0000_0000);
        send_span(10'd100, 10'd130, 10'd0);
        send_span(10'd100, 10'd130, 10'd5);
        send_span(10'd100, 10'd130, 10'd10);
        send_span(10'd100, 10'd130, 10'd15);
        drain();

        cfg_write(CFG_SPARE_IDX, {$urandom, $urandom});
        cfg_write(CFG_DRAW_MODE, 64'd1);
        cfg_write(CFG_WORDS_PER_ROW, 64'd1);
        send_span(10'd7, 10'd7, 10'd511);
        drain();
    endtask

    task automatic test_random_spans();
        logic [COL_W-1:0] xa;
        logic [COL_W-1:0] xb;
        logic [COL_W-1:0] r;
        int               phase;
        int               k;
        int               width;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            in_idle  = (phase != 1 && phase != 3);
            out_idle = (phase != 2 && phase != 3);
            cfg_write(CFG_DRAW_MODE, {$urandom, $urandom});
            case ($urandom_range(0, 5))
                0:       cfg_write(CFG_WORDS_PER_ROW, 64'd0);
                1:       cfg_write(CFG_WORDS_PER_ROW, 64'd2047);
                default: cfg_write(CFG_WORDS_PER_ROW, 64'($urandom_range(1, 1024)));
            endcase
            cfg_write(CFG_FRAME_BASE, {$urandom, $urandom});
            cfg_write(CFG_PATT_A, {$urandom, $urandom});
            cfg_write(CFG_PATT_B, {$urandom, $urandom});
            cfg_write(CFG_PATT_C, {$urandom, $urandom});
            cfg_write(CFG_PATT_D, {$urandom, $urandom});
            for (k = 0; k < PHASE_SPANS; k++) begin
                xa    = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
                // mostly short spans, now and then anything up to a full row
                width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_COLUMNS - 1)
                                                    : $urandom_range(0, 48);
                xb    = (int'(xa) + width > MAX_COLUMNS - 1) ? COL_LAST
                                                            : COL_W'(int'(xa) + width);
                r     = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
                if ($urandom_range(0, 1))
                    send_span(xb, xa, r);
                else
                    send_span(xa, xb, r);
            end
            drain();
        end
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    // Hold the output off while spans keep coming, so the input has to stall
    task automatic test_output_hold();
        int k;
        in_idle  = 1'b0;
        out_idle = 1'b0;
        hold_req = HOLD_CYCLES;
        for (k = 0; k < 10; k++)
            send_span(COL_W'(k * 37), COL_W'(k * 37 + 40), COL_W'(k * 101));
        drain();
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    initial begin
        fb_cfg.draw_mode     = MODE_RESET;
        fb_cfg.words_per_row = PITCH_RESET;
        fb_cfg.frame_base    = BASE_RESET;
        for (int g = 0; g < PATT_GROUPS; g++)
            fb_cfg.patt[g] = PATT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_register_extremes();
        test_output_hold();
        test_random_spans();
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
